// ===== rtl/ecal_pkg.sv =====
// Shared constants, types and the month length table for the epoch-seconds
// to calendar converter. No dependencies; every other file imports it.
package ecal_pkg;

  // Input width and the widths derived from it
  localparam int unsigned SECONDS_WIDTH = 36;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned YEARS_PER_CENTURY = 100;
  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned TM_YEAR_BASE  = 1900;
  // 1970-01-01 was a Thursday
  localparam int unsigned EPOCH_WEEKDAY = 4;
  localparam int unsigned LEAPS_BEFORE_EPOCH =
      (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100 + (EPOCH_YEAR - 1) / 400;

  localparam longint unsigned MAX_SECONDS = (64'd1 << SECONDS_WIDTH) - 64'd1;
  localparam longint unsigned MAX_DAYS    = MAX_SECONDS / SECS_PER_DAY;
  localparam longint unsigned MAX_YEARS   = MAX_DAYS / DAYS_PER_YEAR;
  localparam longint unsigned MAX_YEAR    = EPOCH_YEAR + MAX_YEARS;

  localparam int unsigned DAYS_W = $clog2(MAX_DAYS + 1);
  localparam int unsigned YEAR_W = $clog2(MAX_YEAR + 1);
  localparam int unsigned CENT_W = $clog2(MAX_YEAR / YEARS_PER_CENTURY + 1);
  // Signed day remainder: its magnitude stays below the year itself
  localparam int unsigned REM_W  = YEAR_W + 1;
  localparam int unsigned MTOT_W = 11;

  // Shift-subtract divider: quotient bits retired per cycle
  localparam int unsigned STEP_BITS  = 4;
  localparam int unsigned DIV_CYCLES = (SECONDS_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned DIV_W      = DIV_CYCLES * STEP_BITS;
  localparam int unsigned DVS_W      = 17;
  localparam int unsigned CNT_W      = $clog2(DIV_CYCLES + 1);

  // Output field widths
  localparam int unsigned YOUT_W = 12;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned MDAY_W = 5;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned WDAY_W = 3;
  localparam int unsigned YDAY_W = 9;

  localparam logic [MON_W-1:0] MONTH_FEB  = 4'd1;
  localparam logic [MON_W-1:0] MONTH_LAST = 4'd11;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_p1;     // capture seconds, start days split
    logic ld_p2;     // start year, weekday and minute splits
    logic ld_p3;     // start century and hour splits
    logic step;      // advance all dividers
    logic setup;     // form first day remainder
    logic fix_step;  // step back one year
    logic yday_ld;   // capture day of year
    logic mon_step;  // consume one month
    logic out_ld;    // load result register
  } ecal_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rem_neg;
    logic mon_stop;
  } ecal_sts_t;

  typedef struct packed {
    logic [YOUT_W-1:0] years_since_1900;
    logic [MON_W-1:0]  month_index;
    logic [MDAY_W-1:0] day_of_month;
    logic [HOUR_W-1:0] hour_of_day;
    logic [MIN_W-1:0]  minute_of_hour;
    logic [SEC_W-1:0]  second_of_minute;
    logic [WDAY_W-1:0] weekday;
    logic [YDAY_W-1:0] day_of_year;
  } ecal_result_t;

  // Days in month m, February lengthened in leap years
  function automatic logic [MDAY_W-1:0] month_len(logic [MON_W-1:0] m, logic leap);
    logic [MDAY_W-1:0] len;
    case (m)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/ecal_if.sv =====
// Request and result channel interfaces (valid, ready, payload).
// Depends on ecal_pkg for field widths.
interface ecal_req_if import ecal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [SECONDS_WIDTH-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_rsp_if import ecal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [YOUT_W-1:0] years_since_1900;
  logic [MON_W-1:0]  month_index;
  logic [MDAY_W-1:0] day_of_month;
  logic [HOUR_W-1:0] hour_of_day;
  logic [MIN_W-1:0]  minute_of_hour;
  logic [SEC_W-1:0]  second_of_minute;
  logic [WDAY_W-1:0] weekday;
  logic [YDAY_W-1:0] day_of_year;

  modport source (output valid, output years_since_1900, output month_index,
                  output day_of_month, output hour_of_day, output minute_of_hour,
                  output second_of_minute, output weekday, output day_of_year,
                  input ready);
  modport sink   (input valid, input years_since_1900, input month_index,
                  input day_of_month, input hour_of_day, input minute_of_hour,
                  input second_of_minute, input weekday, input day_of_year,
                  output ready);
endinterface

// ===== rtl/ecal_div.sv =====
// Restoring shift-subtract divider, STEP_BITS quotient bits per step.
// Depends on ecal_pkg for widths.
module ecal_div import ecal_pkg::*; (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             step_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [DIV_W-1:0] quo_o,
  output logic [DVS_W-1:0] rem_o
);

  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q;
  logic [DVS_W:0]       part;
  logic [STEP_BITS-1:0] qbits;

  // Retire the top dividend bits against the divisor
  always_comb begin
    part  = {1'b0, rem_q};
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      part = {part[DVS_W-1:0], dvd_q[DIV_W-1-i]};
      if (part >= {1'b0, dvs_q}) begin
        part = part - {1'b0, dvs_q};
        qbits[STEP_BITS-1-i] = 1'b1;
      end
    end
    rem_d = part[DVS_W-1:0];
    quo_d = {quo_q[DIV_W-STEP_BITS-1:0], qbits};
    dvd_d = {dvd_q[DIV_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
  end

  // Load operands or advance one step
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      quo_q <= '0;
      rem_q <= '0;
    end else if (step_i) begin
      dvd_q <= dvd_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o = quo_q;
  assign rem_o = rem_q;

endmodule

// ===== rtl/ecal_dp.sv =====
// Datapath: three dividers, year correction, month search, result register.
// Depends on ecal_pkg and ecal_div.
module ecal_dp import ecal_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [SECONDS_WIDTH-1:0] epoch_seconds_i,
  input  ecal_cmd_t                cmd_i,
  output ecal_sts_t                sts_o,
  output ecal_result_t             res_o
);

  logic [DIV_W-1:0] dvd0, dvd1, dvd2;
  logic [DVS_W-1:0] dvs0, dvs1, dvs2;
  logic [DIV_W-1:0] quo0, quo1, quo2;
  logic [DVS_W-1:0] rem0, rem1, rem2;

  logic [YEAR_W-1:0] year_q, year_new;
  logic [8:0]        r365_q;
  logic [WDAY_W-1:0] wday_q;
  logic [SEC_W-1:0]  sec_q;
  logic [HOUR_W-1:0] hour_q;
  logic [MIN_W-1:0]  min_q;
  logic [REM_W-1:0]  rem_q, rem_init, mon_diff;
  logic [CENT_W-1:0] cent_q, cent_n;
  logic [6:0]        cyr_q, cyr_n;
  logic              leap_q, leap_init, leap_prev;
  logic [MON_W-1:0]  month_q;
  logic [YDAY_W-1:0] yday_q;
  logic [YEAR_W-1:0] ym1;
  logic [MDAY_W-1:0] mlen;
  ecal_result_t      res_q;

  // Pick divider operands for each phase
  always_comb begin
    dvd0 = DIV_W'(epoch_seconds_i);
    dvs0 = DVS_W'(SECS_PER_DAY);
    dvd1 = DIV_W'(quo0[DAYS_W-1:0]) + DIV_W'(EPOCH_WEEKDAY);
    dvs1 = DVS_W'(DAYS_PER_WEEK);
    dvd2 = DIV_W'(rem0);
    dvs2 = DVS_W'(SECS_PER_MIN);
    if (cmd_i.ld_p2) begin
      dvd0 = DIV_W'(quo0[DAYS_W-1:0]);
      dvs0 = DVS_W'(DAYS_PER_YEAR);
    end else if (cmd_i.ld_p3) begin
      dvd0 = DIV_W'(quo0[YEAR_W-1:0]) + DIV_W'(EPOCH_YEAR - 1);
      dvs0 = DVS_W'(YEARS_PER_CENTURY);
      dvd1 = DIV_W'(quo2[MTOT_W-1:0]);
      dvs1 = DVS_W'(SECS_PER_MIN);
    end
  end

  ecal_div u_div0 (
    .clk_i      (clk_i),
    .load_i     (cmd_i.ld_p1 | cmd_i.ld_p2 | cmd_i.ld_p3),
    .step_i     (cmd_i.step),
    .dividend_i (dvd0),
    .divisor_i  (dvs0),
    .quo_o      (quo0),
    .rem_o      (rem0)
  );

  ecal_div u_div1 (
    .clk_i      (clk_i),
    .load_i     (cmd_i.ld_p2 | cmd_i.ld_p3),
    .step_i     (cmd_i.step),
    .dividend_i (dvd1),
    .divisor_i  (dvs1),
    .quo_o      (quo1),
    .rem_o      (rem1)
  );

  ecal_div u_div2 (
    .clk_i      (clk_i),
    .load_i     (cmd_i.ld_p2),
    .step_i     (cmd_i.step),
    .dividend_i (dvd2),
    .divisor_i  (dvs2),
    .quo_o      (quo2),
    .rem_o      (rem2)
  );

  // First remainder: days into the estimated year, minus leap days since epoch
  assign cent_n = quo0[CENT_W-1:0];
  assign cyr_n  = rem0[6:0];
  assign ym1    = year_q - YEAR_W'(1);
  assign rem_init = REM_W'(r365_q) - REM_W'(ym1 >> 2) + REM_W'(cent_n)
                  - REM_W'(cent_n >> 2) + REM_W'(LEAPS_BEFORE_EPOCH);
  // Year after (100*cent + cyr) is the current year
  assign leap_init = ((year_q[1:0] == 2'd0) && (cyr_n != 7'd99))
                   || ((cyr_n == 7'd99) && (cent_q[1:0] == 2'd3) && 1'b0)
                   || ((cyr_n == 7'd99) && (cent_n[1:0] == 2'd3));
  // Leap status of the year before the current one
  assign year_new  = ym1;
  assign leap_prev = ((ym1[1:0] == 2'd0) && (cyr_q != 7'd0))
                   || ((cyr_q == 7'd0) && (cent_q[1:0] == 2'd0));

  assign mlen     = month_len(month_q, leap_q);
  assign mon_diff = rem_q - REM_W'(mlen);

  assign sts_o.rem_neg  = rem_q[REM_W-1];
  assign sts_o.mon_stop = (month_q == MONTH_LAST) || mon_diff[REM_W-1];

  // Sequence the working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_p3) begin
      year_q <= YEAR_W'(quo0[YEAR_W-1:0]) + YEAR_W'(EPOCH_YEAR);
      r365_q <= rem0[8:0];
      wday_q <= rem1[WDAY_W-1:0];
      sec_q  <= rem2[SEC_W-1:0];
    end
    if (cmd_i.setup) begin
      rem_q   <= rem_init;
      cent_q  <= cent_n;
      cyr_q   <= cyr_n;
      leap_q  <= leap_init;
      hour_q  <= quo1[HOUR_W-1:0];
      min_q   <= rem1[MIN_W-1:0];
      month_q <= '0;
    end
    if (cmd_i.fix_step) begin
      year_q <= year_new;
      leap_q <= leap_prev;
      rem_q  <= rem_q + REM_W'(DAYS_PER_YEAR) + REM_W'(leap_prev);
      if (cyr_q == 7'd0) begin
        cyr_q  <= 7'd99;
        cent_q <= cent_q - CENT_W'(1);
      end else begin
        cyr_q <= cyr_q - 7'd1;
      end
    end
    if (cmd_i.yday_ld) begin
      yday_q <= rem_q[YDAY_W-1:0] + YDAY_W'(1);
    end
    if (cmd_i.mon_step) begin
      rem_q   <= mon_diff;
      month_q <= month_q + MON_W'(1);
    end
    if (cmd_i.out_ld) begin
      res_q.years_since_1900 <= ym1[YOUT_W-1:0] + YOUT_W'(1)
                              - YOUT_W'(TM_YEAR_BASE);
      res_q.month_index      <= month_q;
      res_q.day_of_month     <= rem_q[MDAY_W-1:0] + MDAY_W'(1);
      res_q.hour_of_day      <= hour_q;
      res_q.minute_of_hour   <= min_q;
      res_q.second_of_minute <= sec_q;
      res_q.weekday          <= wday_q;
      res_q.day_of_year      <= yday_q;
    end
  end

  assign res_o = res_q;

  // The month search only consumes whole months
  a_mon_step_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_i.mon_step |-> !rem_q[REM_W-1] && !mon_diff[REM_W-1])
    else $error("month step would leave a negative day count");

  // A delivered day lies inside its month
  a_day_in_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_i.out_ld |-> !rem_q[REM_W-1] && (rem_q < REM_W'(mlen)))
    else $error("day of month beyond month length");

endmodule

// ===== rtl/ecal_ctrl.sv =====
// Controller: sequences the divider phases, year fix-up and month search,
// and owns the request handshakes. Depends on ecal_pkg.
module ecal_ctrl import ecal_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ecal_cmd_t cmd_o,
  input  ecal_sts_t sts_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV1  = 3'd1;
  localparam logic [2:0] S_DIV2  = 3'd2;
  localparam logic [2:0] S_DIV3  = 3'd3;
  localparam logic [2:0] S_SETUP = 3'd4;
  localparam logic [2:0] S_FIX   = 3'd5;
  localparam logic [2:0] S_MONTH = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             cnt_last;

  assign cnt_last   = (cnt_q == CNT_W'(DIV_CYCLES));
  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_p1 = 1'b1;
          cnt_d       = CNT_W'(1);
          state_d     = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_last ? '0 : cnt_q + CNT_W'(1);
        if (cnt_last) state_d = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.ld_p2 = (cnt_q == '0);
        cmd_o.step  = (cnt_q != '0);
        cnt_d       = cnt_last ? '0 : cnt_q + CNT_W'(1);
        if (cnt_last) state_d = S_DIV3;
      end
      S_DIV3: begin
        cmd_o.ld_p3 = (cnt_q == '0);
        cmd_o.step  = (cnt_q != '0);
        cnt_d       = cnt_last ? '0 : cnt_q + CNT_W'(1);
        if (cnt_last) state_d = S_SETUP;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_FIX;
      end
      S_FIX: begin
        if (sts_i.rem_neg) begin
          cmd_o.fix_step = 1'b1;
        end else begin
          cmd_o.yday_ld = 1'b1;
          state_d       = S_MONTH;
        end
      end
      S_MONTH: begin
        if (sts_i.mon_stop) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mon_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, step counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted request starts the days split with the step counter at one
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o |=> state_q == S_DIV1 && cnt_q == CNT_W'(1))
    else $error("accepted request did not start the day split");

  // A finished item waits while the result slot is still occupied
  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == S_DONE && out_valid_q && !out_ready_i |=> state_q == S_DONE)
    else $error("result overwritten before it was taken");

  // A new result appears only from the done state
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result valid raised outside the done state");

endmodule

// ===== rtl/epoch_seconds_to_calendar.sv =====
// Epoch seconds to calendar converter. An accepted request runs through three
// divider phases, the remainder setup, a year step-back repeated while the day
// remainder is negative, a month walk and the result load, in that order. One
// request in flight; the next is taken once the current result is registered.
// Reset is async, low.
module epoch_seconds_to_calendar import ecal_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ecal_req_if.sink   req_i,
  ecal_rsp_if.source rsp_o
);

  ecal_cmd_t    cmd;
  ecal_sts_t    sts;
  ecal_result_t res;

  ecal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ecal_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .epoch_seconds_i (req_i.epoch_seconds),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .res_o           (res)
  );

  // Drive result payload
  assign rsp_o.years_since_1900 = res.years_since_1900;
  assign rsp_o.month_index      = res.month_index;
  assign rsp_o.day_of_month     = res.day_of_month;
  assign rsp_o.hour_of_day      = res.hour_of_day;
  assign rsp_o.minute_of_hour   = res.minute_of_hour;
  assign rsp_o.second_of_minute = res.second_of_minute;
  assign rsp_o.weekday          = res.weekday;
  assign rsp_o.day_of_year      = res.day_of_year;

endmodule

// ===== dv/tb.sv =====
// Testbench for epoch_seconds_to_calendar: drives epoch seconds requests and checks
// every calendar result against an in-bench Gregorian breakdown.
// Depends on ecal_pkg, the ecal_req_if / ecal_rsp_if interfaces and the DUT.
`timescale 1ns / 1ps

module tb;
  import ecal_pkg::*;

  localparam longint FIRST_YEAR = 1970;
  localparam longint TM_BASE    = 1900;
  localparam longint DAY_SECS   = 86400;
  localparam longint HOUR_SECS  = 3600;
  localparam longint MIN_SECS   = 60;
  localparam longint WEEK_DAYS  = 7;
  // 1970-01-01 was a Thursday
  localparam longint EPOCH_WDAY = 4;
  localparam longint TOP_SECONDS = (64'sd1 <<< SECONDS_WIDTH) - 64'sd1;
  localparam longint TOP_YEAR    = 4147;
  localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  localparam int RANDOM_ITEMS   = 1880;
  localparam int IDLE_PCT       = 6;
  localparam int QUIET_FROM     = 700;
  localparam int QUIET_TO       = 1000;
  localparam int HOLD_AT        = 1200;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     req_valid   = 1'b0;
  logic [SECONDS_WIDTH-1:0] req_seconds = '0;
  logic                     rsp_ready   = 1'b0;
  logic                     req_taken   = 1'b0;

  logic [SECONDS_WIDTH-1:0] seconds_q [$];
  ecal_result_t             calendar_q [$];

  int     n_sent       = 0;
  int     n_checked    = 0;
  int     n_errors     = 0;
  int     n_leap_days  = 0;
  int     stall_cycles = 0;
  int     hold_left    = 0;
  bit     held_off     = 1'b0;
  longint top_year_seen = 0;

  ecal_req_if req_if ();
  ecal_rsp_if rsp_if ();

  assign req_if.valid         = req_valid;
  assign req_if.epoch_seconds = req_seconds;
  assign rsp_if.ready         = rsp_ready;

  epoch_seconds_to_calendar DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Gregorian leap rule: every 4th year, except centuries not divisible by 400
  function automatic bit is_leap(longint yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  // Leap days from year 1 through the end of year yr
  function automatic longint leaps_upto(longint yr);
    return yr / 4 - yr / 100 + yr / 400;
  endfunction

  function automatic longint days_before_year(longint yr);
    return (yr - FIRST_YEAR) * 365 + leaps_upto(yr - 1) - leaps_upto(FIRST_YEAR - 1);
  endfunction

  function automatic longint month_days(int m, longint yr);
    return DAYS_IN_MONTH[m] + ((m == MONTH_FEB && is_leap(yr)) ? 1 : 0);
  endfunction

  // Seconds count for day yday0 (from 0) of year yr, sod seconds into that day
  function automatic longint secs_at(longint yr, longint yday0, longint sod);
    return (days_before_year(yr) + yday0) * DAY_SECS + sod;
  endfunction

  // Calendar breakdown of one seconds count
  function automatic ecal_result_t calendar_of(logic [SECONDS_WIDTH-1:0] s);
    ecal_result_t res;
    longint t;
    longint days;
    longint sod;
    longint yr;
    longint rem;
    int     m;
    t    = longint'(s);
    days = t / DAY_SECS;
    sod  = t % DAY_SECS;
    yr   = FIRST_YEAR + days / 365;
    rem  = days - days_before_year(yr);
    // step back while the year estimate overshoots
    while (rem < 0) begin
      yr  = yr - 1;
      rem = rem + (is_leap(yr) ? 366 : 365);
    end
    res.day_of_year = YDAY_W'(rem + 1);
    m = 0;
    while (m < MONTH_LAST && rem >= month_days(m, yr)) begin
      rem = rem - month_days(m, yr);
      m++;
    end
    res.years_since_1900 = YOUT_W'(yr - TM_BASE);
    res.month_index      = MON_W'(m);
    res.day_of_month     = MDAY_W'(rem + 1);
    res.hour_of_day      = HOUR_W'(sod / HOUR_SECS);
    res.minute_of_hour   = MIN_W'((sod % HOUR_SECS) / MIN_SECS);
    res.second_of_minute = SEC_W'(sod % MIN_SECS);
    res.weekday          = WDAY_W'((days + EPOCH_WDAY) % WEEK_DAYS);
    return res;
  endfunction

  function automatic int field_diff(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Driver: offer the next request once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!req_valid || req_taken)) begin
      if (seconds_q.size() != 0 &&
          ((n_sent >= QUIET_FROM && n_sent < QUIET_TO) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        req_seconds <= seconds_q.pop_front();
        req_valid   <= 1'b1;
        n_sent++;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back up the input
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (!held_off && n_checked >= HOLD_AT) begin
      held_off  = 1'b1;
      hold_left = HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= (n_checked >= QUIET_FROM && n_checked < QUIET_TO) ||
                   ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on request accept, compare on result accept
  always @(posedge clk_i) begin
    ecal_result_t want;
    ecal_result_t got;
    bit           moved;
    req_taken <= req_valid && req_if.ready;
    if (rst_ni) begin
      moved = 1'b0;
      if (req_if.valid && req_if.ready) begin
        calendar_q.push_back(calendar_of(req_if.epoch_seconds));
        moved = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        got.years_since_1900 = rsp_if.years_since_1900;
        got.month_index      = rsp_if.month_index;
        got.day_of_month     = rsp_if.day_of_month;
        got.hour_of_day      = rsp_if.hour_of_day;
        got.minute_of_hour   = rsp_if.minute_of_hour;
        got.second_of_minute = rsp_if.second_of_minute;
        got.weekday          = rsp_if.weekday;
        got.day_of_year      = rsp_if.day_of_year;
        if (calendar_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %p", $time, got);
          n_errors++;
        end else begin
          want = calendar_q.pop_front();
          n_errors += field_diff("years_since_1900", want.years_since_1900,
                                 got.years_since_1900);
          n_errors += field_diff("month_index", want.month_index, got.month_index);
          n_errors += field_diff("day_of_month", want.day_of_month, got.day_of_month);
          n_errors += field_diff("hour_of_day", want.hour_of_day, got.hour_of_day);
          n_errors += field_diff("minute_of_hour", want.minute_of_hour,
                                 got.minute_of_hour);
          n_errors += field_diff("second_of_minute", want.second_of_minute,
                                 got.second_of_minute);
          n_errors += field_diff("weekday", want.weekday, got.weekday);
          n_errors += field_diff("day_of_year", want.day_of_year, got.day_of_year);
          if (want.month_index == MONTH_FEB && want.day_of_month == 29)
            n_leap_days++;
          if (longint'(want.years_since_1900) > top_year_seen)
            top_year_seen = longint'(want.years_since_1900);
        end
        n_checked++;
      end
      // Watchdog on cycles without any handshake
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("epoch_seconds_to_calendar regression: fail");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    longint s;
    longint yr;
    int     pick;

    // Time-of-day extremes, year ends, leap and century rules, 32-bit edges
    seconds_q.push_back('0);
    seconds_q.push_back(SECONDS_WIDTH'(TOP_SECONDS));
    seconds_q.push_back(SECONDS_WIDTH'(59));
    seconds_q.push_back(SECONDS_WIDTH'(60));
    seconds_q.push_back(SECONDS_WIDTH'(3599));
    seconds_q.push_back(SECONDS_WIDTH'(3600));
    seconds_q.push_back(SECONDS_WIDTH'(86399));
    seconds_q.push_back(SECONDS_WIDTH'(86400));
    seconds_q.push_back(SECONDS_WIDTH'(secs_at(1971, 364, 86399)));
    seconds_q.push_back(SECONDS_WIDTH'(secs_at(1972, 59, 43200)));
    seconds_q.push_back(SECONDS_WIDTH'(secs_at(1972, 365, 0)));
    seconds_q.push_back(SECONDS_WIDTH'(secs_at(1973, 0, 0)));
    seconds_q.push_back(SECONDS_WIDTH'(secs_at(2000, 59, 0)));
    seconds_q.push_back(SECONDS_WIDTH'(secs_at(2000, 365, 86399)));
    seconds_q.push_back(SECONDS_WIDTH'(secs_at(2100, 58, 0)));
    seconds_q.push_back(SECONDS_WIDTH'(secs_at(2100, 59, 0)));
    seconds_q.push_back(SECONDS_WIDTH'(secs_at(2100, 364, 86399)));
    seconds_q.push_back(SECONDS_WIDTH'(secs_at(2400, 59, 3661)));
    seconds_q.push_back(SECONDS_WIDTH'(secs_at(TOP_YEAR, 0, 0)));
    seconds_q.push_back(SECONDS_WIDTH'(64'd2147483647));
    seconds_q.push_back(SECONDS_WIDTH'(64'd2147483648));
    seconds_q.push_back(SECONDS_WIDTH'(64'd4294967295));
    seconds_q.push_back(SECONDS_WIDTH'(64'd4294967296));

    // Random mix: full range, around year boundaries, inside years, near the epoch
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        s = longint'({$urandom, $urandom}) & TOP_SECONDS;
      end else if (pick < 70) begin
        yr = longint'($urandom_range(TOP_YEAR, FIRST_YEAR + 1));
        s  = secs_at(yr, longint'($urandom_range(7)) - 4, longint'($urandom_range(86399)));
      end else if (pick < 85) begin
        yr = longint'($urandom_range(2500, FIRST_YEAR));
        s  = secs_at(yr, longint'($urandom_range(is_leap(yr) ? 365 : 364)),
                     longint'($urandom_range(86399)));
      end else begin
        s = longint'($urandom_range(400 * 86400));
      end
      if (s > TOP_SECONDS)
        s = s % (TOP_SECONDS + 1);
      seconds_q.push_back(SECONDS_WIDTH'(s));
    end

    // Hold reset, then release it on a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (seconds_q.size() != 0 || req_valid) @(posedge clk_i);
    while (calendar_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d timestamps up to year %0d, %0d of them landing on Feb 29,",
             n_checked, top_year_seen + TM_BASE, n_leap_days);
    $display("with random stalls on both channels and one long result hold-off.");
    if (n_errors == 0) begin
      $display("epoch_seconds_to_calendar regression: pass");
    end else begin
      $display("epoch_seconds_to_calendar regression: fail");
    end
    $finish;
  end

endmodule
